### hw/rtl/kcc_pkg.sv
// ----------------------------------------------------------------------------
// kcc_pkg: shared types and constants for the keypad click classifier
// Word layouts, event kinds, register map and the key priority decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package kcc_pkg;

	// Event kinds reported with each result word.
	typedef enum logic [1:0] {
		KIND_SINGLE = 2'd0,
		KIND_DOUBLE = 2'd1,
		KIND_LONG   = 2'd2
	} press_kind_t;

	// Register indexes on the configuration port (byte address is 4 * index).
	localparam logic [1:0] REG_LONG_PRESS    = 2'd0;
	localparam logic [1:0] REG_SINGLE_DELAY  = 2'd1;
	localparam logic [1:0] REG_DEBOUNCE_REL  = 2'd2;
	localparam logic [1:0] REG_RELEASE_CAP   = 2'd3;

	// Reset values of the registers and of the release counter.
	localparam logic [7:0] LONG_PRESS_RESET   = 8'd200;
	localparam logic [7:0] SINGLE_DELAY_RESET = 8'd60;
	localparam logic [4:0] DEBOUNCE_RESET     = 5'd2;
	localparam logic [7:0] RELEASE_CAP_RESET  = 8'd250;

	// Code returned when no key is down.
	localparam logic [7:0] KEY_NONE = 8'h00;

	typedef struct packed {
		logic [3:0] scan_all_high;
		logic [2:0] scan_line3_driven;
		logic [1:0] scan_line2_driven;
		logic [0:0] scan_line1_driven;
	} in_word_t;

	typedef struct packed {
		logic [7:0]  key_char;
		press_kind_t press_kind;
	} out_word_t;

	// Fixed priority decode of the four active-low snapshots.
	function automatic logic [7:0] decode_key(input in_word_t w);
		logic [7:0] key;
		key = KEY_NONE;
		if (!w.scan_all_high[3]) key = 8'h61;          // 'a'
		else if (!w.scan_all_high[2]) key = 8'h39;     // '9'
		else if (!w.scan_all_high[1]) key = 8'h38;     // '8'
		else if (!w.scan_all_high[0]) key = 8'h37;     // '7'
		else if (!w.scan_line3_driven[2]) key = 8'h36; // '6'
		else if (!w.scan_line3_driven[1]) key = 8'h35; // '5'
		else if (!w.scan_line3_driven[0]) key = 8'h34; // '4'
		else if (!w.scan_line2_driven[1]) key = 8'h33; // '3'
		else if (!w.scan_line2_driven[0]) key = 8'h32; // '2'
		else if (!w.scan_line1_driven[0]) key = 8'h31; // '1'
		return key;
	endfunction

endpackage

`default_nettype wire

### hw/rtl/keypad_click_classifier.sv
// ----------------------------------------------------------------------------
// keypad_click_classifier: single, double and long press detector
// Decodes one scan word per tick and classifies key activity into events.
// ----------------------------------------------------------------------------
// Usage. Each input word carries the four active-low scan snapshots of one
// timer tick. The word is captured in an input register, and from there
// short logic updates the press and release counters and, when an
// event occurs, loads a result word (key code and event kind) into the
// output register. A tick produces zero or one result word.
// out_valid rises once the word leaves the input register with an event.
// One word is accepted every cycle while in_stall is low; the output
// register decouples the two channels, so a new word is taken while a
// finished result still waits. in_stall rises only when the input register
// holds a word that produces an event while the output register is full
// and stalled; words that produce no event pass through even then. Reset
// clears both registers, restores the counters (press count zero, release
// count at the cap) and the configuration registers to their defaults. The
// user must write the configuration port only while the block is idle; the
// block itself does not enforce it. pready is always high.
// ----------------------------------------------------------------------------
`default_nettype none

module keypad_click_classifier (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire kcc_pkg::in_word_t    in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output kcc_pkg::out_word_t        out_data,
	input  wire logic                 psel,
	input  wire logic                 penable,
	input  wire logic                 pwrite,
	input  wire logic [3:0]           paddr,
	input  wire logic [31:0]          pwdata,
	output logic [31:0]               prdata,
	output logic                      pready
);

	// Configuration registers.
	logic [7:0] long_press_q;
	logic [7:0] single_delay_q;
	logic [4:0] debounce_q;
	logic [7:0] release_cap_q;

	// Classifier state.
	logic [7:0] press_count_q;
	logic [7:0] release_count_q;
	logic [7:0] last_key_q;

	// Input register stage.
	logic              valid_s1;
	kcc_pkg::in_word_t word_s1;

	// Output register.
	logic               out_valid_q;
	kcc_pkg::out_word_t out_word_q;

	// Combinational results of the single pass.
	logic                 key_down;
	logic [7:0]           key;
	logic [7:0]           press_inc;
	logic [8:0]           release_inc;
	logic [7:0]           press_next;
	logic [7:0]           release_next;
	logic                 emit;
	kcc_pkg::press_kind_t kind;
	logic                 out_free;
	logic                 advance;
	logic                 cfg_write;

	assign pready    = 1'b1;
	assign cfg_write = psel && penable && pwrite;

	// Register writes. Values wider than a field are truncated to it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			long_press_q   <= kcc_pkg::LONG_PRESS_RESET;
			single_delay_q <= kcc_pkg::SINGLE_DELAY_RESET;
			debounce_q     <= kcc_pkg::DEBOUNCE_RESET;
			release_cap_q  <= kcc_pkg::RELEASE_CAP_RESET;
		end else if (cfg_write) begin
			case (paddr[3:2])
				kcc_pkg::REG_LONG_PRESS:   long_press_q   <= pwdata[7:0];
				kcc_pkg::REG_SINGLE_DELAY: single_delay_q <= pwdata[7:0];
				kcc_pkg::REG_DEBOUNCE_REL: debounce_q     <= pwdata[4:0];
				kcc_pkg::REG_RELEASE_CAP:  release_cap_q  <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Register reads return the value zero-extended to the data width.
	always_comb begin
		case (paddr[3:2])
			kcc_pkg::REG_LONG_PRESS:   prdata = {24'd0, long_press_q};
			kcc_pkg::REG_SINGLE_DELAY: prdata = {24'd0, single_delay_q};
			kcc_pkg::REG_DEBOUNCE_REL: prdata = {27'd0, debounce_q};
			kcc_pkg::REG_RELEASE_CAP:  prdata = {24'd0, release_cap_q};
			default:                   prdata = 32'd0;
		endcase
	end

	// The input register drains whenever its word either produces no event
	// or the output register can take the event.
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && (!emit || out_free);
	assign in_stall = valid_s1 && !advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (!in_stall) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && !in_stall) begin
			word_s1 <= in_data;
		end
	end

	// Classification of the registered tick against the current counters.
	always_comb begin
		key          = kcc_pkg::decode_key(word_s1);
		key_down     = (key != kcc_pkg::KEY_NONE);
		press_inc    = press_count_q + 8'd1;
		release_inc  = {1'b0, release_count_q} + 9'd1;
		press_next   = press_count_q;
		release_next = release_count_q;
		emit         = 1'b0;
		kind         = kcc_pkg::KIND_SINGLE;
		if (key_down) begin
			press_next = press_inc;
			if (press_inc == 8'd1) begin
				// First tick of a press: just count it.
			end else if (press_inc == 8'd2) begin
				if (release_count_q < single_delay_q) begin
					// Second press inside the double window.
					emit         = 1'b1;
					kind         = kcc_pkg::KIND_DOUBLE;
					press_next   = long_press_q + 8'd1;
					release_next = single_delay_q + 8'd1;
				end else begin
					release_next = 8'd0;
				end
			end else if (press_inc == long_press_q) begin
				// Long press; stepping back one count makes it repeat.
				emit         = 1'b1;
				kind         = kcc_pkg::KIND_LONG;
				release_next = single_delay_q + 8'd1;
				press_next   = long_press_q - 8'd1;
			end
		end else begin
			if (release_inc >= {1'b0, release_cap_q}) begin
				release_next = release_cap_q;
			end else begin
				release_next = release_inc[7:0];
				if (release_inc >= {4'd0, debounce_q}) begin
					press_next = 8'd0;
					if (release_inc == {1'b0, single_delay_q}) begin
						emit = 1'b1;
						kind = kcc_pkg::KIND_SINGLE;
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			press_count_q   <= 8'd0;
			release_count_q <= kcc_pkg::RELEASE_CAP_RESET;
			last_key_q      <= kcc_pkg::KEY_NONE;
		end else if (advance) begin
			press_count_q   <= press_next;
			release_count_q <= release_next;
			if (key_down) begin
				last_key_q <= key;
			end
		end
	end

	// Output register: loads on an event, clears once the word is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_free) begin
			out_valid_q <= advance && emit;
		end
	end

	always_ff @(posedge clk) begin
		if (advance && emit) begin
			out_word_q.key_char   <= key_down ? key : last_key_q;
			out_word_q.press_kind <= kind;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_word_q;

	// The input side only backs up when a held word has an event to deliver.
	assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (valid_s1 && emit && out_valid_q && out_stall))
		else $error("input stalled without a blocked event");

	// An event that leaves the input register shows up as a result word.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit) |=> out_valid_q)
		else $error("event lost on its way to the output register");

	// A double sets the press count to one above the long threshold.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && emit && kind == kcc_pkg::KIND_DOUBLE)
			|=> (press_count_q == $past(long_press_q) + 8'd1))
		else $error("press count not moved past threshold after a double");

	// Release counting never passes the cap while the cap is unchanged.
	assert property (@(posedge clk) disable iff (!arst_n)
		(advance && !key_down && release_count_q <= release_cap_q && !cfg_write)
			|=> (release_count_q <= release_cap_q))
		else $error("release count went beyond its cap");

endmodule

`default_nettype wire
